FILE: rtl/lcdx_pkg.sv
// Package with the request types, command codes and result generation functions.
package lcdx_pkg;

  // Input request kinds.
  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;

  // Control command codes.
  localparam logic [4:0] CMD_ON           = 5'd1;
  localparam logic [4:0] CMD_OFF          = 5'd2;
  localparam logic [4:0] CMD_CLEAR        = 5'd3;
  localparam logic [4:0] CMD_RESET        = 5'd4;
  localparam logic [4:0] CMD_CURSOR_LEFT  = 5'd5;
  localparam logic [4:0] CMD_CURSOR_RIGHT = 5'd6;
  localparam logic [4:0] CMD_DISP_LEFT    = 5'd7;
  localparam logic [4:0] CMD_DISP_RIGHT   = 5'd8;
  localparam logic [4:0] CMD_CURSOR_CHAR  = 5'd10;
  localparam logic [4:0] CMD_HOME         = 5'd11;
  localparam logic [4:0] CMD_SELECT       = 5'd12;
  localparam logic [4:0] CMD_CURSOR_OFF   = 5'd14;
  localparam logic [4:0] CMD_CURSOR_ON    = 5'd15;
  localparam logic [4:0] CMD_CURSOR_POS   = 5'd17;
  localparam logic [4:0] CMD_BLINK_OFF    = 5'd18;
  localparam logic [4:0] CMD_CONTRAST     = 5'd19;

  // Bus bits and waits.
  localparam logic [7:0]  RS_BIT     = 8'h10;
  localparam logic [7:0]  ADDR_BIT   = 8'h80;
  localparam logic [1:0]  CTL_BOTH   = 2'b11;
  localparam logic [1:0]  MASK_RESET = 2'd2;
  localparam logic [6:0]  WAIT_EXEC  = 7'd80;
  localparam logic [12:0] WAIT_FIRST = 13'd5000;
  localparam logic [12:0] WAIT_STEP  = 13'd150;
  localparam logic [12:0] WAIT_INIT  = 13'd300;
  localparam logic [12:0] WAIT_CLEAR = 13'd3150;
  localparam logic [4:0]  INIT_RAW_WRITES = 5'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] code;
    logic [7:0] value;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  block_command;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [6:0]  pre_wait_us;
    logic [12:0] post_wait_us;
    logic        status;
    logic        last;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_step;
    logic out_free;
  } dp_status_t;

  // Command bytes sent during initialization.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h0F;
      3'd2:    b = 8'h06;
      3'd3:    b = 8'h80;
      3'd4:    b = 8'h02;
      3'd5:    b = 8'h0C;
      3'd6:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte number idx of a control command.
  function automatic logic [7:0] cmd_byte(input logic [4:0] code, input logic [7:0] value,
                                          input logic [3:0] idx);
    logic [7:0] b;
    case (code)
      CMD_ON, CMD_CURSOR_ON: b = 8'h0F;
      CMD_OFF:               b = 8'h08;
      CMD_CLEAR:             b = 8'h01;
      CMD_RESET:             b = (idx < 4'd4) ? 8'h3F : ((idx == 4'd4) ? 8'h01 : 8'h06);
      CMD_CURSOR_LEFT:       b = 8'h10;
      CMD_CURSOR_RIGHT:      b = 8'h14;
      CMD_DISP_LEFT:         b = 8'h18;
      CMD_DISP_RIGHT:        b = 8'h1C;
      CMD_CURSOR_CHAR:       b = (idx == 4'd0) ? value : 8'h10;
      CMD_HOME:              b = 8'h02;
      CMD_CURSOR_OFF:        b = 8'h0C;
      CMD_CURSOR_POS:        b = value | ADDR_BIT;
      CMD_BLINK_OFF:         b = 8'h0E;
      default:               b = 8'h00;
    endcase
    return b;
  endfunction

  // Number of results that one request produces.
  function automatic logic [4:0] result_count(input in_item_t item, input logic nul_seen);
    logic [4:0] n;
    case (item.kind)
      KIND_INIT: n = 5'd18;
      KIND_CMD: begin
        if (item.code inside {CMD_ON, CMD_OFF, CMD_CLEAR, CMD_CURSOR_LEFT, CMD_CURSOR_RIGHT,
                              CMD_DISP_LEFT, CMD_DISP_RIGHT, CMD_HOME, CMD_CURSOR_OFF,
                              CMD_CURSOR_ON, CMD_CURSOR_POS, CMD_BLINK_OFF}) begin
          n = 5'd2;
        end else if (item.code == CMD_RESET) begin
          n = 5'd12;
        end else if (item.code == CMD_CURSOR_CHAR) begin
          n = 5'd4;
        end else if (item.code inside {CMD_SELECT, CMD_CONTRAST}) begin
          n = 5'd0;
        end else begin
          n = 5'd1;
        end
      end
      KIND_TEXT: n = (!nul_seen && item.value != 8'h00) ? 5'd2 : 5'd0;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // Builds one expander write from its nibble, controllers and waits.
  function automatic out_item_t make_write(input logic [7:0] nib, input logic [1:0] ctl,
                                           input logic [6:0] pre, input logic [12:0] post);
    out_item_t r;
    r.write_valid   = 1'b1;
    r.block_command = nib;
    r.first_byte    = nib | {ctl[1], ctl[0], 6'b0};
    r.second_byte   = nib;
    r.pre_wait_us   = pre;
    r.post_wait_us  = post;
    r.status        = 1'b0;
    r.last          = 1'b0;
    return r;
  endfunction

  // Result number step of a request; the last flag is added by the caller.
  function automatic out_item_t build_result(input in_item_t item, input logic [4:0] step,
                                             input logic [1:0] mask);
    out_item_t  r;
    logic [4:0] init_step;
    logic [7:0] b;
    logic [7:0] rs;
    logic [7:0] nib;
    init_step = 5'(step - INIT_RAW_WRITES);
    r = '0;
    case (item.kind)
      KIND_INIT: begin
        if (step < INIT_RAW_WRITES) begin
          nib = (step == 5'd3) ? 8'h02 : 8'h03;
          r = make_write(nib, CTL_BOTH, 7'd0, (step == 5'd0) ? WAIT_FIRST : WAIT_STEP);
        end else begin
          b = init_cmd(init_step[3:1]);
          if (step[0]) begin
            r = make_write({4'h0, b[3:0]}, CTL_BOTH, 7'd0, WAIT_INIT);
          end else begin
            r = make_write({4'h0, b[7:4]}, CTL_BOTH, 7'd0, 13'd0);
          end
        end
      end
      KIND_CMD: begin
        if (result_count(item, 1'b0) == 5'd1) begin
          // Unknown code: a lone error result.
          r.status = 1'b1;
        end else begin
          b  = cmd_byte(item.code, item.value, step[4:1]);
          rs = (item.code == CMD_CURSOR_CHAR && step[4:1] == 4'd0) ? RS_BIT : 8'h00;
          if (step[0]) begin
            r = make_write({4'h0, b[3:0]} | rs, mask, 7'd0,
                           (item.code == CMD_CLEAR) ? WAIT_CLEAR : WAIT_STEP);
          end else begin
            r = make_write({4'h0, b[7:4]} | rs, mask, WAIT_EXEC, 13'd0);
          end
        end
      end
      KIND_TEXT: begin
        if (step[0]) begin
          r = make_write({4'h0, item.value[3:0]} | RS_BIT, mask, 7'd0, WAIT_STEP);
        end else begin
          r = make_write({4'h0, item.value[7:4]} | RS_BIT, mask, 7'd0, 13'd0);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lcdx_ctrl.sv
// Controller state machine that sequences request capture and result loading.
module lcdx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdx_pkg::dp_status_t st,
  output lcdx_pkg::dp_cmd_t    cmd
);
  import lcdx_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.load    = 1'b0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (st.empty) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.load = 1'b1;
          if (st.last_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/lcdx_datapath.sv
// Datapath holding the request, the sequencing state and the result register.
module lcdx_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdx_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdx_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data,
  input  lcdx_pkg::dp_cmd_t    cmd,
  output lcdx_pkg::dp_status_t st
);
  import lcdx_pkg::*;

  in_item_t   item_r;
  logic [4:0] count_r;
  logic [4:0] step_r;
  logic [1:0] mask_r;
  logic       nul_seen_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  result;

  // Control state: controller mask, NUL flag and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      nul_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_data;
      end else if (cmd.capture && in_data.kind == KIND_CMD && in_data.code == CMD_SELECT) begin
        mask_r <= in_data.value[1:0];
      end
      if (cmd.capture && in_data.kind == KIND_TEXT) begin
        if (in_data.end_of_buffer) begin
          nul_seen_r <= 1'b0;
        end else if (in_data.value == 8'h00) begin
          nul_seen_r <= 1'b1;
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and step counting.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r  <= in_data;
      count_r <= result_count(in_data, nul_seen_r);
      step_r  <= 5'd0;
    end else if (cmd.load) begin
      step_r <= 5'(step_r + 5'd1);
    end
  end

  // Result for the current step.
  always_comb begin
    result      = build_result(item_r, step_r, mask_r);
    result.last = st.last_step;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= result;
    end
  end

  assign st.empty     = (count_r == 5'd0);
  assign st.last_step = (step_r == 5'(count_r - 5'd1));
  assign st.out_free  = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

FILE: rtl/char_lcd_expander_sequencer_top.sv
// Top level of the character display expander write sequencer.
// Each request is taken in and then yields its results one by one: 18 expander writes for
// initialize, 2 to 12 for a command, 2 for a character, 1 error result for an unknown
// command; a request that yields no result sends the block back to idle. The result register
// paces the run at one write per cycle while out_stall is low. The next request is taken as
// soon as the last write of the previous one has been loaded into the result register.
module char_lcd_expander_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdx_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdx_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data
);
  import lcdx_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Controller.
  lcdx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  lcdx_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: rtl/lcdx_checker.sv
// Port-level checker for the sequencer and its bind to the top level.
module lcdx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lcdx_pkg::out_item_t out_data
);
  import lcdx_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result is either a write or an error, never both or neither.
  a_write_or_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.write_valid ^ out_data.status))
    else $error("result is neither a write nor an error");

  // An error result is always the final result of its request.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last)
    else $error("error result not marked last");

  // The second byte always equals the bus command byte.
  a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.second_byte == out_data.block_command)
    else $error("second byte differs from command byte");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while the previous one is still in work");

endmodule

bind char_lcd_expander_sequencer_top lcdx_checker u_lcdx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
